@@ rtl/core/isst_pkg.sv @@
package isst_pkg;

  localparam int ACC_FRAC        = 24;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int TABLE_LEN       = 24;
  localparam int XW              = 44;
  localparam int AW              = 34;
  localparam int SW              = 32;
  localparam int RW              = 32;
  localparam int REMW            = 34;

  localparam logic CFG_ACCEL_RANGE = 1'b0;
  localparam logic CFG_GYRO_RANGE  = 1'b1;

  typedef logic signed [XW-1:0] cx_t;
  typedef logic signed [AW-1:0] ang_t;

  localparam ang_t DEG180 = ang_t'(180) <<< ACC_FRAC;

  typedef struct packed {
    cx_t  x;
    cx_t  y;
    ang_t ang;
  } cvec_t;

  typedef struct packed {
    logic signed [19:0] accel_x;
    logic signed [19:0] accel_y;
    logic signed [19:0] accel_z;
    logic signed [26:0] rate_x;
    logic signed [26:0] rate_y;
    logic signed [26:0] rate_z;
    cvec_t              roll;
    cx_t                pitch_y;
    logic               roll_zero;
    logic               roll_neg;
    logic               pitch_zero;
  } side_t;

  function automatic ang_t atan_deg(input int i);
    ang_t a;
    case (i)
      0:  a = ang_t'(754974720);
      1:  a = ang_t'(445687602);
      2:  a = ang_t'(235489088);
      3:  a = ang_t'(119537938);
      4:  a = ang_t'(60000934);
      5:  a = ang_t'(30029717);
      6:  a = ang_t'(15018523);
      7:  a = ang_t'(7509720);
      8:  a = ang_t'(3754917);
      9:  a = ang_t'(1877466);
      10: a = ang_t'(938734);
      11: a = ang_t'(469367);
      12: a = ang_t'(234683);
      13: a = ang_t'(117342);
      14: a = ang_t'(58671);
      15: a = ang_t'(29335);
      16: a = ang_t'(14668);
      17: a = ang_t'(7334);
      18: a = ang_t'(3667);
      19: a = ang_t'(1833);
      20: a = ang_t'(917);
      21: a = ang_t'(458);
      22: a = ang_t'(229);
      23: a = ang_t'(115);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/imu_sample_scale_and_tilt_core.sv @@
// Scales one raw inertial sample (accelerations to g, rates to degrees per second)
// and derives roll and pitch from the accelerometer. A sample is taken at every
// clock edge with start high; busy never rises. Each result appears on the
// outputs for one cycle with done high, after passing through the input stage,
// which registers at the edge that takes its start, then one set-up stage, 32
// stages of the bit-per-stage square root for the pitch radius, one CORDIC stage
// per iteration (stages capped at 24) and one output stage. The receiver
// cannot stall; results are not held.
module imu_sample_scale_and_tilt_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data,
  input  logic signed [15:0] raw_accel_x,
  input  logic signed [15:0] raw_accel_y,
  input  logic signed [15:0] raw_accel_z,
  input  logic signed [15:0] raw_gyro_x,
  input  logic signed [15:0] raw_gyro_y,
  input  logic signed [15:0] raw_gyro_z,
  output logic               done,
  output logic signed [19:0] accel_x,
  output logic signed [19:0] accel_y,
  output logic signed [19:0] accel_z,
  output logic signed [26:0] rate_x_dps,
  output logic signed [26:0] rate_y_dps,
  output logic signed [26:0] rate_z_dps,
  output logic signed [16:0] roll_deg,
  output logic signed [15:0] pitch_deg
);
  import isst_pkg::*;

  localparam int NST = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int LAT = NST + 35;
  localparam int RSH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [AW:0] HALF = (AW+1)'(1) <<< (RSH - 1);
  localparam logic signed [AW:0] ROLL_LIM = (AW+1)'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [AW:0] PITCH_LIM = (AW+1)'(90) <<< ANGLE_FRAC_BITS;

  logic [1:0] accel_range;
  logic [1:0] gyro_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_range <= '0;
      gyro_range  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ACCEL_RANGE) accel_range <= cfg_data;
      else                              gyro_range  <= cfg_data;
    end
  end

  assign busy = 1'b0;

  logic acc;
  assign acc = start && !busy;

  // input stage
  logic               p1_v;
  logic signed [15:0] p1_ax, p1_ay, p1_az;
  logic signed [19:0] p1_acc [3];
  logic signed [26:0] p1_rate [3];
  logic [30:0]        p1_sqy, p1_sqz;
  logic signed [31:0] sqy_c, sqz_c;
  logic signed [19:0] ain [3];
  logic signed [26:0] gin [3];
  logic [2:0]         ash;

  assign sqy_c = raw_accel_y * raw_accel_y;
  assign sqz_c = raw_accel_z * raw_accel_z;
  assign ash   = {1'b0, accel_range} + 3'd1;
  assign ain[0] = 20'(raw_accel_x);
  assign ain[1] = 20'(raw_accel_y);
  assign ain[2] = 20'(raw_accel_z);
  assign gin[0] = 27'(raw_gyro_x);
  assign gin[1] = 27'(raw_gyro_y);
  assign gin[2] = 27'(raw_gyro_z);

  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else     p1_v <= acc;
  end

  always_ff @(posedge clk) begin
    p1_ax  <= raw_accel_x;
    p1_ay  <= raw_accel_y;
    p1_az  <= raw_accel_z;
    p1_sqy <= sqy_c[30:0];
    p1_sqz <= sqz_c[30:0];
    for (int k = 0; k < 3; k++) begin
      p1_acc[k]  <= ain[k] <<< ash;
      p1_rate[k] <= (gin[k] * 27'sd250) <<< gyro_range;
    end
  end

  // set-up stage
  logic             sv [0:32+NST];
  side_t            side [0:32+NST];
  logic [SW-1:0]    sq_s [0:31];
  logic [RW-1:0]    sq_r [0:32];
  logic [REMW-1:0]  sq_rem [0:32];
  side_t            side0;
  cx_t              ayx, azx, axx;

  always_comb begin
    ayx = cx_t'(p1_ay) <<< ACC_FRAC;
    azx = cx_t'(p1_az) <<< ACC_FRAC;
    axx = cx_t'(p1_ax) <<< ACC_FRAC;
    side0.accel_x    = p1_acc[0];
    side0.accel_y    = p1_acc[1];
    side0.accel_z    = p1_acc[2];
    side0.rate_x     = p1_rate[0];
    side0.rate_y     = p1_rate[1];
    side0.rate_z     = p1_rate[2];
    side0.roll_zero  = (p1_ay == '0);
    side0.roll_neg   = p1_az[15];
    side0.pitch_zero = (p1_ax == '0);
    side0.pitch_y    = -axx;
    if (p1_az[15]) begin
      side0.roll.x   = -azx;
      side0.roll.y   = -ayx;
      side0.roll.ang = p1_ay[15] ? -DEG180 : DEG180;
    end else begin
      side0.roll.x   = azx;
      side0.roll.y   = ayx;
      side0.roll.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else     sv[0] <= p1_v;
  end

  always_ff @(posedge clk) begin
    side[0]   <= side0;
    sq_s[0]   <= {1'b0, p1_sqy} + {1'b0, p1_sqz};
    sq_r[0]   <= '0;
    sq_rem[0] <= '0;
  end

  // square root, one root bit per stage
  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam int K = 31 - j;
    logic [63:0]     vfull;
    logic [REMW-1:0] rem_sh, trial;

    assign vfull  = {sq_s[j], 32'b0};
    assign rem_sh = {sq_rem[j][REMW-3:0], vfull[2*K+1 -: 2]};
    assign trial  = {sq_r[j], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else     sv[j+1] <= sv[j];
    end

    if (j < 31) begin : g_pass
      always_ff @(posedge clk) begin
        sq_s[j+1] <= sq_s[j];
      end
    end

    always_ff @(posedge clk) begin
      side[j+1] <= side[j];
      if (rem_sh >= trial) begin
        sq_rem[j+1] <= rem_sh - trial;
        sq_r[j+1]   <= {sq_r[j][RW-2:0], 1'b1};
      end else begin
        sq_rem[j+1] <= rem_sh;
        sq_r[j+1]   <= {sq_r[j][RW-2:0], 1'b0};
      end
    end
  end

  // cordic stages for roll and pitch side by side
  cvec_t roll_c  [0:NST];
  cvec_t pitch_c [0:NST];

  assign roll_c[0]      = side[32].roll;
  assign pitch_c[0].x   = cx_t'({sq_r[32], 8'b0});
  assign pitch_c[0].y   = side[32].pitch_y;
  assign pitch_c[0].ang = '0;

  for (genvar i = 0; i < NST; i++) begin : g_cordic
    isst_cordic_stage #(.SHIFT(i)) u_roll (
      .clk (clk),
      .d   (roll_c[i]),
      .q   (roll_c[i+1])
    );

    isst_cordic_stage #(.SHIFT(i)) u_pitch (
      .clk (clk),
      .d   (pitch_c[i]),
      .q   (pitch_c[i+1])
    );

    always_ff @(posedge clk) begin
      if (rst) sv[33+i] <= 1'b0;
      else     sv[33+i] <= sv[32+i];
    end

    always_ff @(posedge clk) begin
      side[33+i] <= side[32+i];
    end
  end

  // output stage
  side_t              sf;
  ang_t               roll_a, pitch_a;
  logic signed [AW:0] roll_q, pitch_q, roll_cl, pitch_cl;

  assign sf = side[32+NST];

  always_comb begin
    if (sf.roll_zero) roll_a = sf.roll_neg ? DEG180 : '0;
    else              roll_a = roll_c[NST].ang;
    pitch_a = sf.pitch_zero ? '0 : pitch_c[NST].ang;
    roll_q  = ((AW+1)'(roll_a) + HALF) >>> RSH;
    pitch_q = ((AW+1)'(pitch_a) + HALF) >>> RSH;
    roll_cl = roll_q;
    if (roll_q > ROLL_LIM)  roll_cl = ROLL_LIM;
    if (roll_q < -ROLL_LIM) roll_cl = -ROLL_LIM;
    pitch_cl = pitch_q;
    if (pitch_q > PITCH_LIM)  pitch_cl = PITCH_LIM;
    if (pitch_q < -PITCH_LIM) pitch_cl = -PITCH_LIM;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= sv[32+NST];
  end

  always_ff @(posedge clk) begin
    accel_x    <= sf.accel_x;
    accel_y    <= sf.accel_y;
    accel_z    <= sf.accel_z;
    rate_x_dps <= sf.rate_x;
    rate_y_dps <= sf.rate_y;
    rate_z_dps <= sf.rate_z;
    roll_deg   <= roll_cl[16:0];
    pitch_deg  <= pitch_cl[15:0];
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a start beat");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sv[32] |-> (sq_rem[32] <= {1'b0, sq_r[32], 1'b0}))
    else $error("square root remainder out of bound");

  a_cordic_entry: assert property (@(posedge clk) disable iff (rst)
    sv[32] |-> !pitch_c[0].x[XW-1] && !roll_c[0].x[XW-1])
    else $error("cordic entered with negative x");
`endif

endmodule

@@ rtl/core/isst_cordic_stage.sv @@
module isst_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  isst_pkg::cvec_t d,
  output isst_pkg::cvec_t q
);
  import isst_pkg::*;

  cx_t   xs;
  cx_t   ys;
  cvec_t nxt;

  always_comb begin
    xs = d.x >>> SHIFT;
    ys = d.y >>> SHIFT;
    if (!d.y[XW-1]) begin
      nxt.x   = d.x + ys;
      nxt.y   = d.y - xs;
      nxt.ang = d.ang + atan_deg(SHIFT);
    end else begin
      nxt.x   = d.x - ys;
      nxt.y   = d.y + xs;
      nxt.ang = d.ang - atan_deg(SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    q <= nxt;
  end

endmodule

@@ tb/isst_checker.sv @@
module isst_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data,
  input  logic signed [15:0] raw_accel_x,
  input  logic signed [15:0] raw_accel_y,
  input  logic signed [15:0] raw_accel_z,
  input  logic signed [15:0] raw_gyro_x,
  input  logic signed [15:0] raw_gyro_y,
  input  logic signed [15:0] raw_gyro_z,
  input  logic               done,
  input  logic signed [19:0] accel_x,
  input  logic signed [19:0] accel_y,
  input  logic signed [19:0] accel_z,
  input  logic signed [26:0] rate_x_dps,
  input  logic signed [26:0] rate_y_dps,
  input  logic signed [26:0] rate_z_dps,
  input  logic signed [16:0] roll_deg,
  input  logic signed [15:0] pitch_deg,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import isst_pkg::*;

  localparam int STAGES    = 16;
  localparam int OUT_FRAC  = 8;
  localparam int FRAC      = 24;

  typedef struct {
    logic signed [19:0] ax;
    logic signed [19:0] ay;
    logic signed [19:0] az;
    logic signed [26:0] gx;
    logic signed [26:0] gy;
    logic signed [26:0] gz;
    logic signed [16:0] roll;
    logic signed [15:0] pitch;
  } sample_out_t;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ATAN_TAB [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234683, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  logic [1:0] acc_rng;
  logic [1:0] gyr_rng;
  sample_out_t outstanding[$];

  function automatic longint vector_angle(input longint x0, input longint y0);
    longint x, y, xs, ys, a;
    x = x0;
    y = y0;
    a = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        a += ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        a -= ATAN_TAB[i];
      end
    end
    return a;
  endfunction

  function automatic longint root_of(input longint unsigned v0);
    longint unsigned v, r, b;
    v = v0;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint round_clamp(input longint a, input longint lim_deg);
    longint q, lim;
    q = (a + (64'sd1 <<< (FRAC - 1 - OUT_FRAC))) >>> (FRAC - OUT_FRAC);
    lim = lim_deg <<< OUT_FRAC;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic sample_out_t scale_and_tilt(input longint ax, input longint ay,
      input longint az, input longint gx, input longint gy, input longint gz);
    sample_out_t r;
    longint one, d180, x, y, roll, pitch;
    longint unsigned s;
    one = 64'sd1 <<< FRAC;
    d180 = 180 * one;
    r.ax = 20'(ax * (2 << acc_rng));
    r.ay = 20'(ay * (2 << acc_rng));
    r.az = 20'(az * (2 << acc_rng));
    r.gx = 27'(gx * (250 << gyr_rng));
    r.gy = 27'(gy * (250 << gyr_rng));
    r.gz = 27'(gz * (250 << gyr_rng));
    x = az * one;
    y = ay * one;
    if (y == 0) roll = (x < 0) ? d180 : 0;
    else if (x < 0) roll = ((y > 0) ? d180 : -d180) + vector_angle(-x, -y);
    else roll = vector_angle(x, y);
    s = longint'(ay * ay) + longint'(az * az);
    x = root_of(s << 32) * (64'sd1 <<< (FRAC - 16));
    y = -ax * one;
    pitch = (y == 0) ? 0 : vector_angle(x, y);
    r.roll = 17'(round_clamp(roll, 180));
    r.pitch = 16'(round_clamp(pitch, 90));
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d got %0d", $time, name, want, got);
    end
  endtask

  assign pending = outstanding.size();

  always @(posedge clk) begin
    sample_out_t w;
    if (rst) begin
      acc_rng <= '0;
      gyr_rng <= '0;
      errors = 0;
      outstanding.delete();
    end else begin
      if (start && !busy)
        outstanding.push_back(scale_and_tilt(raw_accel_x, raw_accel_y, raw_accel_z,
                                             raw_gyro_x, raw_gyro_y, raw_gyro_z));
      if (done) begin
        if (outstanding.size() == 0) begin
          errors++;
          $display("%0t result beat with nothing expected", $time);
        end else begin
          w = outstanding.pop_front();
          check_field("accel_x", w.ax, accel_x);
          check_field("accel_y", w.ay, accel_y);
          check_field("accel_z", w.az, accel_z);
          check_field("rate_x_dps", w.gx, rate_x_dps);
          check_field("rate_y_dps", w.gy, rate_y_dps);
          check_field("rate_z_dps", w.gz, rate_z_dps);
          check_field("roll_deg", w.roll, roll_deg);
          check_field("pitch_deg", w.pitch, pitch_deg);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ACCEL_RANGE) acc_rng <= cfg_data;
        else gyr_rng <= cfg_data;
      end
    end
  end

endmodule

@@ tb/tb_imu_sample_scale_and_tilt_core.sv @@
module tb_imu_sample_scale_and_tilt_core;
  timeunit 1ns;
  timeprecision 1ps;
  import isst_pkg::*;

  localparam int LATENCY = 51;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [1:0] cfg_data = '0;
  logic signed [15:0] raw_accel_x = '0, raw_accel_y = '0, raw_accel_z = '0;
  logic signed [15:0] raw_gyro_x = '0, raw_gyro_y = '0, raw_gyro_z = '0;
  logic done;
  logic signed [19:0] accel_x, accel_y, accel_z;
  logic signed [26:0] rate_x_dps, rate_y_dps, rate_z_dps;
  logic signed [16:0] roll_deg;
  logic signed [15:0] pitch_deg;
  int errors, pending;
  int quiet_cycles = 0;
  bit no_gaps = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  imu_sample_scale_and_tilt_core i_dut (.*);

  isst_checker i_checker (.*);

  // watchdog on accepted beats
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_imu_sample_scale_and_tilt_core NOT OK");
      $finish;
    end
  end

  task automatic send(input logic signed [15:0] ax, ay, az, gx, gy, gz);
    bit ok;
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start <= 1'b1;
    raw_accel_x <= ax;
    raw_accel_y <= ay;
    raw_accel_z <= az;
    raw_gyro_x <= gx;
    raw_gyro_y <= gy;
    raw_gyro_z <= gz;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_ranges(input logic [1:0] a, input logic [1:0] g);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_ACCEL_RANGE;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= CFG_GYRO_RANGE;
    cfg_data <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3, 4: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0] acc_set [5] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
    logic [1:0] gyr_set [5] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and the tilt corner cases
    send(0, 0, 0, 0, 0, 0);
    send(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(0, 0, 1000, -1, 1, -1);
    send(0, 0, -1000, 1, -1, 1);
    send(500, 16'sh7fff, -1, 2, 3, 4);
    send(-500, 16'sh8000, -1, 5, 6, 7);
    send(16'sh8000, 1, -16384, 0, 0, 0);
    send(16'sh7fff, -1, -16384, 0, 0, 0);
    send(16'sh8000, 0, 0, 0, 0, 0);
    send(16'sh7fff, 0, 0, 0, 0, 0);
    send(0, 16'sh8000, 0, 0, 0, 0);
    send(0, 16'sh7fff, 0, 0, 0, 0);
    send(1, 1, 1, 1, 1, 1);
    send(-1, -1, -1, -1, -1, -1);
    send(16'sh8000, 16'sh8000, 0, 0, 0, 0);
    send(16'sh7fff, 0, 16'sh8000, 0, 0, 0);

    for (int p = 0; p < 5; p++) begin
      set_ranges(acc_set[p], gyr_set[p]);
      if (p == 4) no_gaps = 1;
      send(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      for (int n = 0; n < 390; n++)
        send(pick(), pick(), pick(), pick(), pick(), pick());
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("tb_imu_sample_scale_and_tilt_core OK");
    else $display("tb_imu_sample_scale_and_tilt_core NOT OK");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/isst_pkg.sv
rtl/core/isst_cordic_stage.sv
rtl/core/imu_sample_scale_and_tilt_core.sv
tb/isst_checker.sv
tb/tb_imu_sample_scale_and_tilt_core.sv
